// ===== rtl/n_queens_backtrack_solver_unit_macros.svh =====
// ----------------------------------------------------------------------------
// n_queens_backtrack_solver_unit_macros
// Assertion macros for the n-queens solver modules.
// ----------------------------------------------------------------------------
`ifndef N_QUEENS_BACKTRACK_SOLVER_UNIT_MACROS_SVH
`define N_QUEENS_BACKTRACK_SOLVER_UNIT_MACROS_SVH
`ifndef ASSERT_OFF
`define NQ_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define NQ_ASSERT_NORST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define NQ_ASSERT(label, clk, rst, prop, msg)
`define NQ_ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

// ===== rtl/nqbs_pkg.sv =====
// ----------------------------------------------------------------------------
// nqbs_pkg
// Types and constants shared by the n-queens solver modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
package nqbs_pkg;
  localparam int BoardSizeDefault = 8;

  typedef struct packed {
    logic [2:0] row0_col;
    logic [2:0] row1_col;
  } in_item_t;

  typedef struct packed {
    logic [2:0] row_index;
    logic [2:0] column;
    logic       found;
    logic       last;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_PRE_EMPTY,
    ST_ENTER,
    ST_SEL,
    ST_TRY,
    ST_POST,
    ST_EMIT,
    ST_FAIL
  } state_t;

  typedef struct packed {
    logic load;
    logic enter;
    logic sel_step;
    logic try_col;
    logic back;
    logic emit_step;
  } cmd_t;

  typedef struct packed {
    logic preset_bad;
    logic any_empty;
    logic all_placed;
    logic sel_done;
    logic col_found;
    logic depth_zero;
    logic emit_done;
  } sts_t;
endpackage

// ===== rtl/nqbs_datapath.sv =====
// ----------------------------------------------------------------------------
// nqbs_datapath
// Board state, domain pruning, row selection scan and try-stack.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "n_queens_backtrack_solver_unit_macros.svh"
module nqbs_datapath
  import nqbs_pkg::*;
#(
  parameter int BOARD_SIZE = BoardSizeDefault
) (
  input  logic     clk,
  input  logic     rst,
  input  in_item_t in_item,
  input  cmd_t     cmd,
  output sts_t     sts,
  output logic [2:0] emit_row,
  output logic [2:0] emit_col
);
  localparam int RW = $clog2(BOARD_SIZE);
  localparam int CW = $clog2(BOARD_SIZE + 1);
  localparam int DW = $clog2(BOARD_SIZE + 1);

  logic [RW-1:0] pcol [BOARD_SIZE];
  logic [BOARD_SIZE-1:0] pvalid;
  logic [RW-1:0] crow [BOARD_SIZE];
  logic [CW-1:0] ntry [BOARD_SIZE];
  logic [DW-1:0] depth;
  logic [RW-1:0] scan;
  logic [RW-1:0] best;
  logic [CW-1:0] best_size;
  logic [RW-1:0] erow;

  logic [BOARD_SIZE-1:0] dom [BOARD_SIZE];
  logic [BOARD_SIZE-1:0] dom_ex [BOARD_SIZE];
  logic [RW-1:0] var_row;
  logic [RW-1:0] d_idx;
  logic [CW-1:0] pc_scan;
  logic [CW-1:0] found_col;
  logic          found_any;
  logic [CW-1:0] start_col;
  logic          any_empty;
  logic          preset_bad;

  assign d_idx   = depth[RW-1:0];
  assign var_row = crow[d_idx];

  // domains with all placed rows applied; dom_ex ignores the current var row
  always_comb begin
    for (int j = 0; j < BOARD_SIZE; j++) begin
      dom[j]    = '1;
      dom_ex[j] = '1;
      for (int i = 0; i < BOARD_SIZE; i++) begin
        if (pvalid[i] && i != j) begin
          for (int k = 0; k < BOARD_SIZE; k++) begin
            if (int'(pcol[i]) == k || int'(pcol[i]) - i + j == k ||
                int'(pcol[i]) + i - j == k) begin
              dom[j][k] = 1'b0;
              if (RW'(i) != var_row) dom_ex[j][k] = 1'b0;
            end
          end
        end
      end
    end
  end

  always_comb begin
    pc_scan = '0;
    for (int k = 0; k < BOARD_SIZE; k++) begin
      if (dom[scan][k]) pc_scan = pc_scan + CW'(1);
    end
  end

  assign start_col = ntry[d_idx];
  always_comb begin
    found_any = 1'b0;
    found_col = '0;
    for (int k = BOARD_SIZE - 1; k >= 0; k--) begin
      if (dom_ex[var_row][k] && CW'(k) >= start_col) begin
        found_any = 1'b1;
        found_col = CW'(k);
      end
    end
  end

  always_comb begin
    any_empty = 1'b0;
    for (int j = 0; j < BOARD_SIZE; j++) begin
      if (dom[j] == '0) any_empty = 1'b1;
    end
  end

  assign preset_bad = (int'(in_item.row0_col) >= BOARD_SIZE) ||
                      (int'(in_item.row1_col) >= BOARD_SIZE) ||
                      (in_item.row0_col == in_item.row1_col) ||
                      (int'(in_item.row0_col) - int'(in_item.row1_col) == 1) ||
                      (int'(in_item.row1_col) - int'(in_item.row0_col) == 1);

  assign sts = '{
    preset_bad: preset_bad,
    any_empty:  any_empty,
    all_placed: &pvalid,
    sel_done:   (scan == RW'(BOARD_SIZE - 1)),
    col_found:  found_any,
    depth_zero: (depth == '0),
    emit_done:  (erow == RW'(BOARD_SIZE - 1))
  };
  assign emit_row = 3'(erow);
  assign emit_col = 3'(pcol[erow]);

  always_ff @(posedge clk) begin
    if (rst) begin
      pvalid <= '0;
      depth  <= '0;
      scan   <= '0;
      erow   <= '0;
    end else begin
      if (cmd.load) begin
        pvalid <= BOARD_SIZE'(3);
        pcol[0] <= RW'(in_item.row0_col);
        pcol[1] <= RW'(in_item.row1_col);
        depth <= '0;
        erow  <= '0;
      end
      if (cmd.enter) begin
        scan      <= '0;
        best      <= '0;
        best_size <= CW'(BOARD_SIZE);
      end
      if (cmd.sel_step) begin
        if (!pvalid[scan] && pc_scan < best_size) begin
          best      <= scan;
          best_size <= pc_scan;
        end
        if (sts.sel_done) begin
          crow[d_idx] <= (!pvalid[scan] && pc_scan < best_size) ? scan : best;
          ntry[d_idx] <= '0;
        end else begin
          scan <= scan + RW'(1);
        end
      end
      if (cmd.try_col) begin
        if (found_any) begin
          pvalid[var_row] <= 1'b1;
          pcol[var_row]   <= found_col[RW-1:0];
          ntry[d_idx]     <= found_col + CW'(1);
        end else begin
          pvalid[var_row] <= 1'b0;
          if (depth != '0) depth <= depth - DW'(1);
        end
      end
      if (cmd.back) begin
        if (depth + DW'(1) < DW'(BOARD_SIZE)) depth <= depth + DW'(1);
      end
      if (cmd.emit_step) erow <= erow + RW'(1);
    end
  end

  `NQ_ASSERT(a_depth_range, clk, rst, depth < DW'(BOARD_SIZE), "depth out of range")
  `NQ_ASSERT(a_load_presets, clk, rst, cmd.load |=> (pvalid == BOARD_SIZE'(3)), "presets lost")
  `NQ_ASSERT(a_one_cmd, clk, rst, $onehot0(cmd), "overlapping commands")
endmodule

// ===== rtl/nqbs_ctrl.sv =====
// ----------------------------------------------------------------------------
// nqbs_ctrl
// Sequencer for the search: preset check, row selection, tries, results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "n_queens_backtrack_solver_unit_macros.svh"
module nqbs_ctrl
  import nqbs_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_fire,
  input  logic out_free,
  input  sts_t sts,
  output cmd_t cmd,
  output logic busy,
  output logic push,
  output logic push_found,
  output logic push_last
);
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:      if (in_fire) state_next = ST_CHECK;
      ST_CHECK:     state_next = sts.preset_bad ? ST_FAIL : ST_PRE_EMPTY;
      ST_PRE_EMPTY: state_next = sts.any_empty ? ST_FAIL : ST_ENTER;
      ST_ENTER:     state_next = sts.all_placed ? ST_EMIT : ST_SEL;
      ST_SEL:       if (sts.sel_done) state_next = ST_TRY;
      ST_TRY: begin
        if (sts.col_found) state_next = ST_POST;
        else if (sts.depth_zero) state_next = ST_FAIL;
        else state_next = ST_TRY;
      end
      ST_POST:      state_next = sts.any_empty ? ST_TRY : ST_ENTER;
      ST_EMIT:      if (out_free && sts.emit_done) state_next = ST_IDLE;
      ST_FAIL:      if (out_free) state_next = ST_IDLE;
      default:      state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd        = '0;
    push       = 1'b0;
    push_found = 1'b0;
    push_last  = 1'b0;
    busy       = (state != ST_IDLE);
    unique case (state)
      ST_IDLE:      cmd.load = in_fire;
      ST_CHECK:     ;
      ST_PRE_EMPTY: ;
      ST_ENTER:     cmd.enter = !sts.all_placed;
      ST_SEL:       cmd.sel_step = 1'b1;
      ST_TRY:       cmd.try_col = 1'b1;
      ST_POST:      cmd.back = !sts.any_empty;
      ST_EMIT: begin
        push       = out_free;
        push_found = 1'b1;
        push_last  = sts.emit_done;
        cmd.emit_step = out_free;
      end
      ST_FAIL: begin
        push      = out_free;
        push_last = 1'b1;
      end
      default: ;
    endcase
  end

  `NQ_ASSERT(a_push_state, clk, rst, push |-> (state == ST_EMIT || state == ST_FAIL), "stray push")
  `NQ_ASSERT(a_load_idle, clk, rst, cmd.load |-> (state == ST_IDLE), "load while busy")
  `NQ_ASSERT(a_fail_done, clk, rst, (state == ST_FAIL && out_free) |=> (state == ST_IDLE), "fail hang")
endmodule

// ===== rtl/n_queens_backtrack_solver_unit.sv =====
// ----------------------------------------------------------------------------
// n_queens_backtrack_solver_unit
// Usage: an input transfer gives preset columns for rows zero and one. The
// block searches depth first (fewest free columns first, ascending columns)
// and streams BOARD_SIZE results, one per row in ascending order with last
// on the final one, or one not-found result with found low.
// Sequence: preset checks, then for each placement enter, a row-selection
// scan over all BOARD_SIZE rows, try and a domain check; a try that empties
// a domain goes back to try, and each backtrack step is a further try.
// Results then leave at one per cycle while out_ready is high.
// Throughput: one query at a time; in_ready is high only while idle.
// Reset: clears the sequencer and out_valid; the block is idle.
// Stall: while out_ready is low the result register holds and the sequencer
// waits before its next result; nothing is dropped.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module n_queens_backtrack_solver_unit
  import nqbs_pkg::*;
#(
  parameter int BOARD_SIZE = BoardSizeDefault
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  cmd_t cmd;
  sts_t sts;
  logic busy, push, push_found, push_last, in_fire, out_free;
  logic [2:0] emit_row, emit_col;
  in_item_t item;

  assign in_ready = !busy;
  assign in_fire  = in_valid && in_ready;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (in_fire) item <= in_data;
  end

  nqbs_ctrl u_ctrl (
    .clk, .rst, .in_fire, .out_free, .sts, .cmd, .busy, .push, .push_found, .push_last
  );

  nqbs_datapath #(.BOARD_SIZE(BOARD_SIZE)) u_dp (
    .clk, .rst, .in_item(in_fire ? in_data : item), .cmd, .sts, .emit_row, .emit_col
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (push) begin
      out_valid <= 1'b1;
      out_data.row_index <= push_found ? emit_row : 3'd0;
      out_data.column    <= push_found ? emit_col : 3'd0;
      out_data.found     <= push_found;
      out_data.last      <= push_last;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end
endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Testbench for n_queens_backtrack_solver_unit
// Sends preset column pairs for rows zero and one. A behavioral solver in the
// bench repeats the same depth-first search, with fewest free columns first
// and forward checking. Each output transfer is compared field by field with
// the oldest queued placement. Both sides pause and stall at random.
// ----------------------------------------------------------------------------
module testbench;
  import nqbs_pkg::*;

  localparam int N = BoardSizeDefault;

  typedef struct {
    logic [2:0] c0;
    logic [2:0] c1;
    bit         typed_nf;
  } preset_row_t;

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_ready;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_ready;
  out_item_t out_data;

  n_queens_backtrack_solver_unit dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  out_item_t    placement_q[$];
  int           mismatch_cnt;
  int           queries_sent;
  int           rows_seen;
  int           not_found_cnt;
  bit           calm_sender;
  bit           calm_receiver;

  logic [2:0]   queen_col[N];
  logic [N-1:0] queen_set;
  logic [N-1:0] free_cols[N];
  int           lvl_row[N];
  int           lvl_next[N];

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  function automatic void refresh_free();
    int d1;
    int d2;
    for (int j = 0; j < N; j++) free_cols[j] = '1;
    for (int i = 0; i < N; i++) begin
      if (!queen_set[i]) continue;
      for (int j = 0; j < N; j++) begin
        if (j == i) continue;
        d1 = int'(queen_col[i]) - i + j;
        d2 = int'(queen_col[i]) + i - j;
        free_cols[j][queen_col[i]] = 1'b0;
        if (d1 >= 0 && d1 < N) free_cols[j][d1] = 1'b0;
        if (d2 >= 0 && d2 < N) free_cols[j][d2] = 1'b0;
      end
    end
  endfunction

  function automatic bit some_row_blocked();
    for (int i = 0; i < N; i++) if (free_cols[i] == '0) return 1'b1;
    return 1'b0;
  endfunction

  function automatic int pick_row();
    int best;
    int best_n;
    best = 0;
    best_n = N + 1;
    for (int i = 0; i < N; i++) begin
      if (queen_set[i]) continue;
      if ($countones(free_cols[i]) < best_n) begin
        best_n = $countones(free_cols[i]);
        best = i;
      end
    end
    return best;
  endfunction

  function automatic bit solve_board();
    int  depth;
    int  r;
    int  c;
    bit  entering;
    depth = 0;
    entering = 1'b1;
    forever begin
      if (entering) begin
        if (queen_set == '1) return 1'b1;
        lvl_row[depth] = pick_row();
        lvl_next[depth] = 0;
        entering = 1'b0;
      end
      r = lvl_row[depth];
      queen_set[r] = 1'b0;
      queen_col[r] = '0;
      refresh_free();
      c = lvl_next[depth];
      while (c < N && !free_cols[r][c]) c++;
      if (c >= N) begin
        if (depth == 0) return 1'b0;
        depth--;
        continue;
      end
      lvl_next[depth] = c + 1;
      queen_col[r] = c[2:0];
      queen_set[r] = 1'b1;
      refresh_free();
      if (some_row_blocked()) continue;
      if (depth + 1 < N) depth++;
      entering = 1'b1;
    end
  endfunction

  function automatic void push_not_found();
    out_item_t o;
    o = '{row_index: 3'd0, column: 3'd0, found: 1'b0, last: 1'b1};
    placement_q.insert(placement_q.size(), o);
  endfunction

  function automatic void predict_placement(in_item_t it);
    bit        ok;
    out_item_t o;
    int        dc;
    queen_set = '0;
    for (int i = 0; i < N; i++) queen_col[i] = '0;
    dc = int'(it.row0_col) - int'(it.row1_col);
    ok = (int'(it.row0_col) < N) && (int'(it.row1_col) < N) && dc != 0 && dc != 1 && dc != -1;
    if (ok) begin
      queen_col[0] = it.row0_col;
      queen_col[1] = it.row1_col;
      queen_set[0] = 1'b1;
      queen_set[1] = 1'b1;
      refresh_free();
      ok = !some_row_blocked();
    end
    if (ok) ok = solve_board();
    if (!ok) begin
      push_not_found();
      return;
    end
    for (int i = 0; i < N; i++) begin
      o.row_index = i[2:0];
      o.column = queen_col[i];
      o.found = 1'b1;
      o.last = (i == N - 1);
      placement_q.insert(placement_q.size(), o);
    end
  endfunction

  task automatic flag_mismatch(string what, int got, int want);
    $display("mismatch on %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
    mismatch_cnt++;
  endtask

  task automatic send_query(in_item_t it, bit typed_nf);
    int gap;
    gap = calm_sender ? 0 : $urandom_range(0, 4);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    do @(posedge clk); while (!in_ready);
    if (typed_nf) push_not_found();
    else predict_placement(it);
    queries_sent++;
    @(negedge clk);
  endtask

  always @(posedge clk) begin
    out_item_t want;
    if (!rst && out_valid && out_ready) begin
      rows_seen++;
      if (placement_q.size() == 0) begin
        flag_mismatch("unexpected transfer", 1, 0);
      end else begin
        want = placement_q.pop_front();
        if (!want.found) not_found_cnt++;
        if (out_data.row_index !== want.row_index)
          flag_mismatch("row_index", int'(out_data.row_index), int'(want.row_index));
        if (out_data.column !== want.column)
          flag_mismatch("column", int'(out_data.column), int'(want.column));
        if (out_data.found !== want.found)
          flag_mismatch("found", int'(out_data.found), int'(want.found));
        if (out_data.last !== want.last)
          flag_mismatch("last", int'(out_data.last), int'(want.last));
      end
    end
  end

  initial begin
    int k;
    out_ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      k = calm_receiver ? 0 : $urandom_range(0, 4);
      if (k > 0) begin
        out_ready <= 1'b0;
        repeat (k) @(negedge clk);
      end
      out_ready <= 1'b1;
      do @(posedge clk); while (!out_valid);
      @(negedge clk);
    end
  end

  initial begin
    #50ms;
    $display("timeout at %0t", $realtime);
    $display("FAILURE");
    $finish;
  end

  initial begin
    preset_row_t table_rows[$];
    in_item_t    it;
    int          waited;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;
    mismatch_cnt = 0;
    queries_sent = 0;
    rows_seen = 0;
    not_found_cnt = 0;
    calm_sender = 1'b0;
    calm_receiver = 1'b0;
    table_rows = '{
      '{3'd0, 3'd0, 1'b1}, '{3'd7, 3'd7, 1'b1}, '{3'd3, 3'd4, 1'b1},
      '{3'd4, 3'd3, 1'b1}, '{3'd0, 3'd1, 1'b1}, '{3'd7, 3'd6, 1'b1},
      '{3'd0, 3'd7, 1'b0}, '{3'd7, 3'd0, 1'b0}, '{3'd0, 3'd2, 1'b0},
      '{3'd7, 3'd5, 1'b0}, '{3'd2, 3'd0, 1'b0}, '{3'd5, 3'd7, 1'b0},
      '{3'd0, 3'd4, 1'b0}, '{3'd1, 3'd3, 1'b0}, '{3'd3, 3'd1, 1'b0},
      '{3'd2, 3'd5, 1'b0}, '{3'd6, 3'd2, 1'b0}, '{3'd4, 3'd6, 1'b0},
      '{3'd3, 3'd7, 1'b0}, '{3'd5, 3'd2, 1'b0}, '{3'd1, 3'd6, 1'b0}
    };
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    foreach (table_rows[i]) begin
      it.row0_col = table_rows[i].c0;
      it.row1_col = table_rows[i].c1;
      send_query(it, table_rows[i].typed_nf);
    end
    for (int n = 0; n < 120; n++) begin
      calm_sender = (n >= 40 && n < 60);
      calm_receiver = (n >= 50 && n < 75);
      if (n == 90) begin
        in_valid <= 1'b0;
        while (placement_q.size() != 0) @(negedge clk);
      end
      it.row0_col = 3'($urandom_range(0, 7));
      it.row1_col = 3'($urandom_range(0, 7));
      send_query(it, 1'b0);
    end
    in_valid <= 1'b0;
    while (placement_q.size() != 0) @(negedge clk);
    waited = 0;
    while (waited < 200) begin
      @(negedge clk);
      waited++;
    end
    $display("%0d queries sent, %0d results checked, %0d of them not-found",
             queries_sent, rows_seen, not_found_cnt);
    if (mismatch_cnt == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", mismatch_cnt);
      $display("FAILURE");
    end
    $finish;
  end
endmodule
